>>> hdl/base64_stream_decoder_defines.svh
// Assertion macros shared by the Base64 stream decoder.
// Included by the top level; needs no other file.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_CHECK(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64D_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/b64d_pkg.sv
// Shared types, codes and the alphabet lookup of the Base64 stream decoder.
// Depends on nothing; the front end, queue, back end and top level use it.
`timescale 1ns / 1ps

package b64d_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_LENGTH  = 2'd2
	} status_t;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One queued job: cnt words to send from data (MSB byte first) with status st.
	typedef struct packed {
		logic [23:0] data;
		logic [1:0]  cnt;
		status_t     st;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	// Bit 6 flags an alphabet character; bits 5:0 hold its value.
	function automatic logic [6:0] sextet_of(logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

>>> hdl/b64d_if.sv
// Handshake interfaces for the character input and byte output channels.
// Depends on nothing.
`timescale 1ns / 1ps

interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, in_char, in_last, input ready);
	modport sink (input valid, in_char, in_last, output ready);
endinterface

interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       run_last;

	modport source (output valid, out_byte, status, run_last, input ready);
	modport sink (input valid, out_byte, status, run_last, output ready);
endinterface

>>> hdl/b64d_front.sv
// Front end: accepts characters, tracks the group of four and queues jobs.
// Depends on b64d_pkg and b64d_in_if.
`timescale 1ns / 1ps

module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	b64d_in_if.sink         chars,
	input  logic            full,
	output b64d_pkg::push_t push,
	output logic            dropping
);

	logic [1:0]  pos_q, pos_n;
	logic [23:0] acc_q, acc_n;
	logic [2:0]  pad_q, pad_n;
	logic        err_q, err_n;

	logic        accept;
	logic [6:0]  sx;
	logic        is_pad;
	logic [5:0]  v;
	logic [23:0] placed;
	logic [23:0] acc_sum;
	logic [2:0]  pad_sum;
	logic [1:0]  nbytes;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;
	assign dropping    = err_q;

	assign sx     = b64d_pkg::sextet_of(chars.in_char);
	assign is_pad = (chars.in_char == b64d_pkg::PAD_CHAR);
	assign v      = is_pad ? 6'd0 : sx[5:0];

	always_comb begin
		case (pos_q)
			2'd0:    placed = {v, 18'd0};
			2'd1:    placed = {6'd0, v, 12'd0};
			2'd2:    placed = {12'd0, v, 6'd0};
			default: placed = {18'd0, v};
		endcase
	end

	assign acc_sum = acc_q | placed;
	assign pad_sum = pad_q + 3'(is_pad);
	assign nbytes  = (pad_sum >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_sum);

	always_comb begin
		pos_n = pos_q;
		acc_n = acc_q;
		pad_n = pad_q;
		err_n = err_q;
		push  = '0;
		if (accept) begin
			if (err_q) begin
				// Drop everything up to and including the last character.
				if (chars.in_last) begin
					pos_n = 2'd0;
					acc_n = 24'd0;
					pad_n = 3'd0;
					err_n = 1'b0;
				end
			end else if (!is_pad && !sx[6]) begin
				push.valid       = 1'b1;
				push.entry.data  = 24'd0;
				push.entry.cnt   = 2'd1;
				push.entry.st    = b64d_pkg::ST_INVALID;
				pos_n            = 2'd0;
				acc_n            = 24'd0;
				pad_n            = 3'd0;
				err_n            = !chars.in_last;
			end else begin
				acc_n = acc_sum;
				pad_n = pad_sum;
				pos_n = pos_q + 2'd1;
				if (pos_q == 2'd3) begin
					if (nbytes != 2'd0) begin
						push.valid      = 1'b1;
						push.entry.data = acc_sum;
						push.entry.cnt  = nbytes;
						push.entry.st   = b64d_pkg::ST_OK;
					end
					acc_n = 24'd0;
					pad_n = 3'd0;
				end else if (chars.in_last) begin
					// The text ended inside a group.
					push.valid      = 1'b1;
					push.entry.data = 24'd0;
					push.entry.cnt  = 2'd1;
					push.entry.st   = b64d_pkg::ST_LENGTH;
					pos_n           = 2'd0;
					acc_n           = 24'd0;
					pad_n           = 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			acc_q <= 24'd0;
			pad_q <= 3'd0;
			err_q <= 1'b0;
		end else begin
			pos_q <= pos_n;
			acc_q <= acc_n;
			pad_q <= pad_n;
			err_q <= err_n;
		end
	end

endmodule

>>> hdl/b64d_fifo.sv
// Short job queue between the front end and the byte sender.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::push_t  push,
	input  logic             pop,
	output b64d_pkg::entry_t head,
	output logic             empty,
	output logic             full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	b64d_pkg::entry_t slots_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;

	assign empty = (count_q == CW'(0));
	assign full  = (count_q == CW'(DEPTH));
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/b64d_back.sv
// Back end: sends the head job's words, one per cycle unless stalled.
// Depends on b64d_pkg and b64d_out_if.
`timescale 1ns / 1ps

module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	b64d_out_if.source       bytes
);

	logic [1:0] idx_q;
	logic       fire;
	logic       at_end;

	assign bytes.valid    = !empty;
	assign bytes.status   = head.st;
	assign at_end         = (idx_q == head.cnt - 2'd1);
	assign bytes.run_last = at_end;
	assign fire           = bytes.valid && bytes.ready;
	assign pop            = fire && at_end;

	always_comb begin
		case (idx_q)
			2'd0:    bytes.out_byte = head.data[23:16];
			2'd1:    bytes.out_byte = head.data[15:8];
			default: bytes.out_byte = head.data[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (pop) begin
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

>>> hdl/base64_stream_decoder.sv
// Top level of the streaming Base64 decoder.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_fifo, b64d_back and the defines header.
`timescale 1ns / 1ps
`include "base64_stream_decoder_defines.svh"

// The decoder takes one character word per cycle on chars while its queue has
// room and returns decoded bytes on bytes, one word per cycle while bytes.ready
// is high, most significant byte of each group first. A character is accepted
// whenever the job queue between the front end and the byte sender has a free
// slot (FIFO_DEPTH entries). Four characters yield at most three bytes. When
// the queue is empty, results of a character become visible on bytes the cycle
// after it is accepted. The byte sender sends one result word at a time, so a
// character that closes a group holds its queue slot until all its words have
// gone. An invalid character yields one word with status ST_INVALID; everything
// after it is dropped up to and including the character marked last. A last
// character that leaves a group open yields one extra word with status
// ST_LENGTH. Error words carry a zero byte. run_last marks the final word caused
// by one character. Bytes of earlier groups have already left the block by the
// time a length error shows.
module base64_stream_decoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	b64d_in_if.sink    chars,
	b64d_out_if.source bytes
);

	b64d_pkg::push_t  push;
	b64d_pkg::entry_t head;
	logic             empty;
	logic             full;
	logic             pop;
	logic             dropping;

	// Front end: classifies each character and updates the group state.
	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.full     (full),
		.push     (push),
		.dropping (dropping)
	);

	// Job queue: lets the front end keep accepting while bytes drain.
	b64d_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	// Byte sender: walks the words of the job at the queue head.
	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.bytes  (bytes)
	);

	// An error word is always a single zero-byte word that ends its run.
	`B64D_CHECK(a_err_word, clk, arst_n, bytes.valid && bytes.status != 2'(b64d_pkg::ST_OK), bytes.run_last && bytes.out_byte == 8'd0, "error word not a lone zero byte")
	// While dropping after an error, accepted characters queue nothing.
	`B64D_CHECK(a_drop_quiet, clk, arst_n, dropping && chars.valid && chars.ready, !push.valid, "job queued while dropping")
	// After a job is queued, bytes.valid is high in the next cycle.
	`B64D_CHECK_NEXT(a_push_shows, clk, arst_n, push.valid, bytes.valid, "queued job not visible")

endmodule
